// ----- hw/rtl/fcse_pkg.sv -----
package fcse_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [2:0] K_ADD = 3'd0;
  localparam logic [2:0] K_DEL = 3'd1;
  localparam logic [2:0] K_QRY = 3'd2;
  localparam logic [2:0] K_INT = 3'd3;
  localparam logic [2:0] K_UNI = 3'd4;
  localparam logic [2:0] K_DIF = 3'd5;
  localparam logic [2:0] K_MRG = 3'd6;

  typedef struct packed {
    logic             load;
    logic             probe;
    logic             act;
    logic             fin;
    logic             phase;
    logic [CNT_W-1:0] idx;
  } ctl_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [CNT_W-1:0] cnt_a;
    logic [CNT_W-1:0] cnt_b;
  } sts_t;

endpackage

// ----- hw/rtl/fixed_capacity_set_engine_core.sv -----
// Two sets of up to 16 distinct 32-bit values. Raise start while busy is low to issue a
// request; valid_o pulses once per result and the receiver cannot stall it, so capture every
// pulse. Add, delete and query probe once and then act; intersect, difference and merge
// walk the elements of one set and union walks both sets, where each element gets a
// parallel compare against the target set and then a step that acts on it.
module fixed_capacity_set_engine_core import fcse_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         kind_i,
  input  logic               which_set_i,
  input  logic signed [31:0] value_i,
  output logic               valid_o,
  output logic               flag_o,
  output logic signed [31:0] element_o,
  output logic               last_o,
  output logic [4:0]         count_a_o,
  output logic [4:0]         count_b_o
);

  ctl_t             ctl;
  sts_t             sts;
  logic [CNT_W-1:0] cnt_a, cnt_b;

  fcse_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .busy   (busy),
    .ctl_o  (ctl)
  );

  fcse_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .kind_i      (kind_i),
    .which_set_i (which_set_i),
    .value_i     (value_i),
    .sts_o       (sts),
    .valid_o     (valid_o),
    .flag_o      (flag_o),
    .element_o   (element_o),
    .last_o      (last_o),
    .count_a_o   (cnt_a),
    .count_b_o   (cnt_b)
  );

  assign count_a_o = 5'(cnt_a);
  assign count_b_o = 5'(cnt_b);

endmodule

// ----- hw/rtl/fcse_ctrl.sv -----
module fcse_ctrl import fcse_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  sts_t sts_i,
  output logic busy,
  output ctl_t ctl_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_ACT   = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             phase_q, phase_d;
  logic [CNT_W-1:0] bound;

  always_comb begin
    case (sts_i.kind)
      K_ADD, K_DEL, K_QRY: bound = CNT_W'(1);
      K_INT, K_DIF:        bound = sts_i.cnt_a;
      K_UNI:               bound = phase_q ? sts_i.cnt_b : sts_i.cnt_a;
      K_MRG:               bound = sts_i.cnt_b;
      default:             bound = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    phase_d     = phase_q;
    ctl_o       = '0;
    ctl_o.idx   = idx_q;
    ctl_o.phase = phase_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.load = 1'b1;
          idx_d      = '0;
          phase_d    = 1'b0;
          state_d    = S_PROBE;
        end
      end
      S_PROBE: begin
        if (idx_q >= bound) begin
          if (sts_i.kind == K_UNI && !phase_q) begin
            phase_d = 1'b1;
            idx_d   = '0;
          end else begin
            state_d = S_FIN;
          end
        end else begin
          ctl_o.probe = 1'b1;
          state_d     = S_ACT;
        end
      end
      S_ACT: begin
        ctl_o.act = 1'b1;
        idx_d     = idx_q + CNT_W'(1);
        if (sts_i.kind inside {K_ADD, K_DEL, K_QRY}) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_PROBE;
        end
      end
      S_FIN: begin
        ctl_o.fin = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      phase_q <= phase_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ----- hw/rtl/fcse_dp.sv -----
module fcse_dp import fcse_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctl_t               ctl_i,
  input  logic [2:0]         kind_i,
  input  logic               which_set_i,
  input  logic signed [31:0] value_i,
  output sts_t               sts_o,
  output logic               valid_o,
  output logic               flag_o,
  output logic signed [31:0] element_o,
  output logic               last_o,
  output logic [CNT_W-1:0]   count_a_o,
  output logic [CNT_W-1:0]   count_b_o
);

  logic [31:0]      a_q [CAPACITY];
  logic [31:0]      b_q [CAPACITY];
  logic [CNT_W-1:0] cnt_a_q, cnt_b_q;
  logic [2:0]       kind_q;
  logic             which_q;
  logic [31:0]      value_q;
  logic [31:0]      cand_q, cand_d;
  logic             hit_q, hit_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [31:0]      pend_q;
  logic             pend_v_q;
  logic [CNT_W-1:0] n_q;
  logic             ok_q;
  logic             out_v_q, out_f_q, out_l_q;
  logic [31:0]      out_e_q;

  logic             tgt_b;
  logic [IDX_W-1:0] ridx;
  logic             inc;
  logic             ok_act;
  logic             do_app_a, do_app_b, do_del_a, do_del_b;
  logic [CNT_W-1:0] tgt_cnt;

  assign ridx = ctl_i.idx[IDX_W-1:0];

  always_comb begin
    case (kind_q)
      K_INT, K_DIF: begin
        tgt_b  = 1'b1;
        cand_d = a_q[ridx];
      end
      K_UNI: begin
        tgt_b  = 1'b0;
        cand_d = ctl_i.phase ? b_q[ridx] : a_q[ridx];
      end
      K_MRG: begin
        tgt_b  = 1'b0;
        cand_d = b_q[ridx];
      end
      default: begin
        tgt_b  = which_q;
        cand_d = value_q;
      end
    endcase
    tgt_cnt = tgt_b ? cnt_b_q : cnt_a_q;
    hit_d   = 1'b0;
    pos_d   = '0;
    for (int j = CAPACITY - 1; j >= 0; j--) begin
      if (CNT_W'(j) < tgt_cnt &&
          (tgt_b ? b_q[j] : a_q[j]) == cand_d) begin
        hit_d = 1'b1;
        pos_d = IDX_W'(j);
      end
    end
  end

  always_comb begin
    inc      = 1'b0;
    ok_act   = 1'b0;
    do_app_a = 1'b0;
    do_app_b = 1'b0;
    do_del_a = 1'b0;
    do_del_b = 1'b0;
    case (kind_q)
      K_ADD: begin
        ok_act   = !hit_q && ((which_q ? cnt_b_q : cnt_a_q) < CNT_W'(CAPACITY));
        do_app_a = ok_act && !which_q;
        do_app_b = ok_act && which_q;
      end
      K_DEL: begin
        ok_act   = hit_q;
        do_del_a = hit_q && !which_q;
        do_del_b = hit_q && which_q;
      end
      K_QRY: ok_act = hit_q;
      K_INT: inc = hit_q;
      K_DIF: inc = !hit_q;
      K_UNI: inc = ctl_i.phase ? (!hit_q && n_q < CNT_W'(CAPACITY)) : 1'b1;
      K_MRG: begin
        ok_act   = !hit_q && cnt_a_q < CNT_W'(CAPACITY);
        do_app_a = ok_act;
      end
      default: ok_act = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      kind_q  <= kind_i;
      which_q <= which_set_i;
      value_q <= value_i;
    end
    if (ctl_i.probe) begin
      cand_q <= cand_d;
      hit_q  <= hit_d;
      pos_q  <= pos_d;
    end
    if (ctl_i.act && inc) begin
      pend_q <= cand_q;
    end
    if (ctl_i.act) begin
      if (do_app_a) begin
        a_q[cnt_a_q[IDX_W-1:0]] <= cand_q;
      end
      if (do_app_b) begin
        b_q[cnt_b_q[IDX_W-1:0]] <= cand_q;
      end
      for (int j = 0; j < CAPACITY - 1; j++) begin
        if (do_del_a && IDX_W'(j) >= pos_q) begin
          a_q[j] <= a_q[j+1];
        end
        if (do_del_b && IDX_W'(j) >= pos_q) begin
          b_q[j] <= b_q[j+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q  <= '0;
      cnt_b_q  <= '0;
      pend_v_q <= 1'b0;
      n_q      <= '0;
      ok_q     <= 1'b0;
      out_v_q  <= 1'b0;
      out_f_q  <= 1'b0;
      out_l_q  <= 1'b0;
      out_e_q  <= '0;
    end else begin
      out_v_q <= 1'b0;
      if (ctl_i.load) begin
        pend_v_q <= 1'b0;
        n_q      <= '0;
        ok_q     <= 1'b0;
      end
      if (ctl_i.act) begin
        if (do_app_a) cnt_a_q <= cnt_a_q + CNT_W'(1);
        if (do_app_b) cnt_b_q <= cnt_b_q + CNT_W'(1);
        if (do_del_a) cnt_a_q <= cnt_a_q - CNT_W'(1);
        if (do_del_b) cnt_b_q <= cnt_b_q - CNT_W'(1);
        if (ok_act) ok_q <= 1'b1;
        if (kind_q inside {K_ADD, K_DEL, K_QRY}) begin
          out_v_q <= 1'b1;
          out_f_q <= ok_act;
          out_e_q <= value_q;
          out_l_q <= 1'b1;
        end else if (inc) begin
          pend_v_q <= 1'b1;
          n_q      <= n_q + CNT_W'(1);
          if (pend_v_q) begin
            out_v_q <= 1'b1;
            out_f_q <= 1'b1;
            out_e_q <= pend_q;
            out_l_q <= 1'b0;
          end
        end
      end
      if (ctl_i.fin) begin
        out_v_q <= 1'b1;
        out_l_q <= 1'b1;
        case (kind_q)
          K_INT, K_UNI, K_DIF: begin
            out_f_q <= pend_v_q;
            out_e_q <= pend_v_q ? pend_q : '0;
          end
          K_MRG: begin
            out_f_q <= ok_q;
            out_e_q <= '0;
          end
          default: begin
            out_f_q <= 1'b0;
            out_e_q <= value_q;
          end
        endcase
      end
    end
  end

  assign sts_o.kind  = kind_q;
  assign sts_o.cnt_a = cnt_a_q;
  assign sts_o.cnt_b = cnt_b_q;
  assign valid_o     = out_v_q;
  assign flag_o      = out_f_q;
  assign element_o   = out_e_q;
  assign last_o      = out_l_q;
  assign count_a_o   = cnt_a_q;
  assign count_b_o   = cnt_b_q;

endmodule
